### hw/rtl/bgrf_pkg.sv
// ----------------------------------------------------------------------------
// bgrf_pkg
// Shared types and constants of the banked register file tracker.
// ----------------------------------------------------------------------------
package bgrf_pkg;

  // bank sizes in dwords, matched in this order
  localparam int unsigned CONFIG_WORDS  = 4096;
  localparam int unsigned UCONFIG_WORDS = 4096;
  localparam int unsigned SHADER_WORDS  = 1024;
  localparam int unsigned CONTEXT_WORDS = 1024;

  localparam int unsigned NUM_BANKS   = 4;
  localparam int unsigned TOTAL_WORDS = CONFIG_WORDS + UCONFIG_WORDS + SHADER_WORDS +
                                        CONTEXT_WORDS;
  localparam int unsigned IDX_W       = $clog2(TOTAL_WORDS);
  localparam int unsigned CTX_BANK    = 3;

  localparam int unsigned BANK_WORDS  [NUM_BANKS] = '{CONFIG_WORDS, UCONFIG_WORDS,
                                                      SHADER_WORDS, CONTEXT_WORDS};
  localparam int unsigned BANK_OFFSET [NUM_BANKS] = '{0, CONFIG_WORDS,
                                                      CONFIG_WORDS + UCONFIG_WORDS,
                                                      CONFIG_WORDS + UCONFIG_WORDS +
                                                      SHADER_WORDS};

  // stored entry: written flag above the data word
  localparam int unsigned ENTRY_W = 33;

  // configuration register indexes
  localparam logic [2:0] REG_CONFIG_BASE  = 3'd0;
  localparam logic [2:0] REG_UCONFIG_BASE = 3'd1;
  localparam logic [2:0] REG_SHADER_BASE  = 3'd2;
  localparam logic [2:0] REG_CONTEXT_BASE = 3'd3;
  localparam logic [2:0] REG_SCISSOR_TL   = 3'd4;
  localparam logic [2:0] REG_SCISSOR_BR   = 3'd5;
  localparam logic [2:0] REG_INDEX_TYPE   = 3'd6;

  // counter select codes
  localparam logic [3:0] SEL_WRITES    = 4'd0;
  localparam logic [3:0] SEL_MISSES    = 4'd1;
  localparam logic [3:0] SEL_NAMED     = 4'd2;
  localparam logic [3:0] SEL_INDEX     = 4'd3;
  localparam logic [3:0] SEL_DISPATCH  = 4'd4;
  localparam logic [3:0] SEL_DIM_X     = 4'd5;
  localparam logic [3:0] SEL_DIM_Y     = 4'd6;
  localparam logic [3:0] SEL_DIM_Z     = 4'd7;
  localparam logic [3:0] SEL_SEQUENCE  = 4'd8;

  typedef enum logic [2:0] {
    CMD_WRITE    = 3'd0,
    CMD_READ     = 3'd1,
    CMD_DISPATCH = 3'd2,
    CMD_COUNTER  = 3'd3,
    CMD_CLEAR    = 3'd4
  } cmd_e;

  typedef enum logic [2:0] {
    STS_WRITE_OK   = 3'd0,
    STS_WRITE_MISS = 3'd1,
    STS_READ_HIT   = 3'd2,
    STS_READ_MISS  = 3'd3,
    STS_DISPATCH   = 3'd4,
    STS_COUNTER    = 3'd5,
    STS_CLEARED    = 3'd6
  } status_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_DONE
  } state_e;

  // which memory read data a pending result takes
  typedef enum logic [1:0] {
    MRG_NONE,
    MRG_READ,
    MRG_PAIR
  } merge_e;

  typedef struct packed {
    logic [2:0]  command;
    logic [31:0] address;
    logic [31:0] write_value;
    logic [31:0] dim_x;
    logic [31:0] dim_y;
    logic [31:0] dim_z;
    logic [31:0] packet_offset;
    logic [3:0]  counter_select;
  } in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] data;
    logic        was_written;
    logic        journaled;
    logic [31:0] sequence_res;
    logic [31:0] paired_value;
    logic        paired_valid;
  } out_t;

  // bank match result: first matching bank, and the context bank alone
  typedef struct packed {
    logic             hit;
    logic [IDX_W-1:0] idx;
    logic             ctx_hit;
    logic [IDX_W-1:0] ctx_idx;
  } loc_t;

endpackage

### hw/rtl/banked_gpu_register_file_tracker_unit.sv
// ----------------------------------------------------------------------------
// banked_gpu_register_file_tracker_unit
// Register space tracker: banked word store, named-write stamping, counters.
// ----------------------------------------------------------------------------
// Usage:
//   Commands enter on the in channel (in_valid_i / in_stall_o) and one result
//   item per known command leaves on the out channel (out_valid_o /
//   out_stall_i). Unknown command codes are dropped without a result.
//   Configuration registers are written through cfg_we_i / cfg_index_i /
//   cfg_data_i while the block is idle; index 7 is ignored.
//   Each item steps through the sequencer states (accept, execute against
//   the store, deliver) around the word memory; the next item is accepted
//   only once the sequencer has returned to idle.
//   The output register lets the next item be accepted while a result waits;
//   a stalled result holds and the following item then waits in the
//   sequencer.
//   Reset and the clear command both sweep the store, one entry a cycle
//   over all TOTAL_WORDS (10240) entries, with in_stall_o high throughout.
//   The clear result is delivered after its sweep.
// ----------------------------------------------------------------------------
module banked_gpu_register_file_tracker_unit (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  bgrf_pkg::in_t    in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output bgrf_pkg::out_t   out_data_o,
  input  logic             cfg_we_i,
  input  logic [2:0]       cfg_index_i,
  input  logic [31:0]      cfg_data_i
);

  bgrf_pkg::state_e state_q, state_d;
  bgrf_pkg::in_t    item_q;
  bgrf_pkg::out_t   res_q, res_d;
  bgrf_pkg::merge_e merge_q, merge_d;
  bgrf_pkg::out_t   out_q, out_d;
  logic             out_valid_q, out_valid_d;
  logic             clr_pend_q, clr_pend_d;
  logic [bgrf_pkg::IDX_W-1:0] clr_cnt_q, clr_cnt_d;

  logic [31:0] wr_cnt_q, wr_cnt_d, miss_cnt_q, miss_cnt_d;
  logic [31:0] named_cnt_q, named_cnt_d, idx_cnt_q, idx_cnt_d;
  logic [31:0] disp_cnt_q, disp_cnt_d, seq_q, seq_d;
  logic [31:0] dim_x_q, dim_x_d, dim_y_q, dim_y_d, dim_z_q, dim_z_d;

  logic [bgrf_pkg::NUM_BANKS-1:0][31:0] bases_q;
  logic [31:0] tl_addr_q, br_addr_q, it_addr_q;

  logic                           mem_we, mem_re;
  logic [bgrf_pkg::IDX_W-1:0]     mem_waddr, mem_raddr;
  logic [bgrf_pkg::ENTRY_W-1:0]   mem_wdata, mem_rdata;

  bgrf_pkg::loc_t loc_item, loc_tl;
  logic           out_free, accept, is_named, is_br, is_it, clr_last;
  logic [31:0]    seq_inc;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != bgrf_pkg::ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign clr_last   = (clr_cnt_q == bgrf_pkg::IDX_W'(bgrf_pkg::TOTAL_WORDS - 1));
  assign seq_inc    = seq_q + 32'd1;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bases_q[0] <= 32'd8192;
      bases_q[1] <= 32'd49152;
      bases_q[2] <= 32'd11264;
      bases_q[3] <= 32'd40960;
      tl_addr_q  <= 32'd40972;
      br_addr_q  <= 32'd40973;
      it_addr_q  <= 32'd49731;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        bgrf_pkg::REG_CONFIG_BASE:  bases_q[0] <= cfg_data_i;
        bgrf_pkg::REG_UCONFIG_BASE: bases_q[1] <= cfg_data_i;
        bgrf_pkg::REG_SHADER_BASE:  bases_q[2] <= cfg_data_i;
        bgrf_pkg::REG_CONTEXT_BASE: bases_q[3] <= cfg_data_i;
        bgrf_pkg::REG_SCISSOR_TL:   tl_addr_q  <= cfg_data_i;
        bgrf_pkg::REG_SCISSOR_BR:   br_addr_q  <= cfg_data_i;
        bgrf_pkg::REG_INDEX_TYPE:   it_addr_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // bank lookup for the held item and for the scissor top-left address
  bgrf_locate u_loc_item (
    .bases_i   (bases_q),
    .address_i (item_q.address),
    .loc_o     (loc_item)
  );

  bgrf_locate u_loc_tl (
    .bases_i   (bases_q),
    .address_i (tl_addr_q),
    .loc_o     (loc_tl)
  );

  bgrf_mem u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // named address decode, bottom-right takes precedence over index type
  assign is_br    = (item_q.address == br_addr_q);
  assign is_it    = !is_br && (item_q.address == it_addr_q);
  assign is_named = is_br || is_it || (item_q.address == tl_addr_q);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      bgrf_pkg::ST_IDLE: begin
        if (accept) state_d = bgrf_pkg::ST_EXEC;
      end
      bgrf_pkg::ST_EXEC: begin
        case (item_q.command) inside
          bgrf_pkg::CMD_WRITE, bgrf_pkg::CMD_READ,
          bgrf_pkg::CMD_DISPATCH, bgrf_pkg::CMD_COUNTER: state_d = bgrf_pkg::ST_DONE;
          bgrf_pkg::CMD_CLEAR: state_d = bgrf_pkg::ST_CLEAR;
          default:             state_d = bgrf_pkg::ST_IDLE;
        endcase
      end
      bgrf_pkg::ST_DONE: begin
        if (out_free) state_d = bgrf_pkg::ST_IDLE;
      end
      bgrf_pkg::ST_CLEAR: begin
        if (clr_last) state_d = clr_pend_q ? bgrf_pkg::ST_DONE : bgrf_pkg::ST_IDLE;
      end
      default: state_d = bgrf_pkg::ST_IDLE;
    endcase
  end

  // datapath and outputs of the sequencer
  always_comb begin
    res_d       = res_q;
    merge_d     = merge_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    clr_pend_d  = clr_pend_q;
    clr_cnt_d   = clr_cnt_q;
    wr_cnt_d    = wr_cnt_q;
    miss_cnt_d  = miss_cnt_q;
    named_cnt_d = named_cnt_q;
    idx_cnt_d   = idx_cnt_q;
    disp_cnt_d  = disp_cnt_q;
    seq_d       = seq_q;
    dim_x_d     = dim_x_q;
    dim_y_d     = dim_y_q;
    dim_z_d     = dim_z_q;
    mem_we      = 1'b0;
    mem_waddr   = loc_item.idx;
    mem_wdata   = {1'b1, item_q.write_value};
    mem_re      = 1'b0;
    mem_raddr   = loc_item.idx;

    unique case (state_q)
      bgrf_pkg::ST_EXEC: begin
        res_d   = '0;
        merge_d = bgrf_pkg::MRG_NONE;
        case (item_q.command)
          bgrf_pkg::CMD_WRITE: begin
            if (!loc_item.hit) begin
              miss_cnt_d   = miss_cnt_q + 32'd1;
              res_d.status = bgrf_pkg::STS_WRITE_MISS;
            end else begin
              mem_we       = 1'b1;
              wr_cnt_d     = wr_cnt_q + 32'd1;
              res_d.status = bgrf_pkg::STS_WRITE_OK;
              if (is_named) begin
                seq_d              = seq_inc;
                named_cnt_d        = named_cnt_q + 32'd1;
                res_d.journaled    = 1'b1;
                res_d.sequence_res = seq_inc;
                if (is_br && loc_tl.ctx_hit) begin
                  // read the context-bank top-left entry; forwarded only if it is this write's entry
                  mem_re    = 1'b1;
                  mem_raddr = loc_tl.ctx_idx;
                  merge_d   = bgrf_pkg::MRG_PAIR;
                end
                if (is_it) idx_cnt_d = idx_cnt_q + 32'd1;
              end
            end
          end
          bgrf_pkg::CMD_READ: begin
            if (loc_item.hit) begin
              mem_re       = 1'b1;
              res_d.status = bgrf_pkg::STS_READ_HIT;
              merge_d      = bgrf_pkg::MRG_READ;
            end else begin
              res_d.status = bgrf_pkg::STS_READ_MISS;
            end
          end
          bgrf_pkg::CMD_DISPATCH: begin
            disp_cnt_d         = disp_cnt_q + 32'd1;
            dim_x_d            = item_q.dim_x;
            dim_y_d            = item_q.dim_y;
            dim_z_d            = item_q.dim_z;
            seq_d              = seq_inc;
            res_d.status       = bgrf_pkg::STS_DISPATCH;
            res_d.data         = item_q.packet_offset;
            res_d.sequence_res = seq_inc;
          end
          bgrf_pkg::CMD_COUNTER: begin
            res_d.status = bgrf_pkg::STS_COUNTER;
            unique case (item_q.counter_select)
              bgrf_pkg::SEL_WRITES:   res_d.data = wr_cnt_q;
              bgrf_pkg::SEL_MISSES:   res_d.data = miss_cnt_q;
              bgrf_pkg::SEL_NAMED:    res_d.data = named_cnt_q;
              bgrf_pkg::SEL_INDEX:    res_d.data = idx_cnt_q;
              bgrf_pkg::SEL_DISPATCH: res_d.data = disp_cnt_q;
              bgrf_pkg::SEL_DIM_X:    res_d.data = dim_x_q;
              bgrf_pkg::SEL_DIM_Y:    res_d.data = dim_y_q;
              bgrf_pkg::SEL_DIM_Z:    res_d.data = dim_z_q;
              bgrf_pkg::SEL_SEQUENCE: res_d.data = seq_q;
              default:                res_d.data = '0;
            endcase
          end
          bgrf_pkg::CMD_CLEAR: begin
            wr_cnt_d    = '0;
            miss_cnt_d  = '0;
            named_cnt_d = '0;
            idx_cnt_d   = '0;
            disp_cnt_d  = '0;
            seq_d       = '0;
            dim_x_d     = '0;
            dim_y_d     = '0;
            dim_z_d     = '0;
            clr_pend_d  = 1'b1;
            clr_cnt_d   = '0;
          end
          default: ;
        endcase
      end
      bgrf_pkg::ST_CLEAR: begin
        // zero one entry and its flag per cycle
        mem_we    = 1'b1;
        mem_waddr = clr_cnt_q;
        mem_wdata = '0;
        clr_cnt_d = clr_cnt_q + bgrf_pkg::IDX_W'(1);
        if (clr_last) begin
          clr_pend_d   = 1'b0;
          res_d        = '0;
          res_d.status = bgrf_pkg::STS_CLEARED;
          merge_d      = bgrf_pkg::MRG_NONE;
        end
      end
      bgrf_pkg::ST_DONE: begin
        // merge the registered read data into the result
        if (out_free) begin
          out_valid_d = 1'b1;
          out_d       = res_q;
          case (merge_q)
            bgrf_pkg::MRG_READ: begin
              out_d.data        = mem_rdata[31:0];
              out_d.was_written = mem_rdata[bgrf_pkg::ENTRY_W-1];
            end
            bgrf_pkg::MRG_PAIR: begin
              out_d.paired_value = mem_rdata[31:0];
              out_d.paired_valid = mem_rdata[bgrf_pkg::ENTRY_W-1];
            end
            default: ;
          endcase
        end
      end
      default: ;
    endcase
  end

  // control and counter registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bgrf_pkg::ST_CLEAR;
      out_valid_q <= 1'b0;
      clr_pend_q  <= 1'b0;
      clr_cnt_q   <= '0;
      merge_q     <= bgrf_pkg::MRG_NONE;
      wr_cnt_q    <= '0;
      miss_cnt_q  <= '0;
      named_cnt_q <= '0;
      idx_cnt_q   <= '0;
      disp_cnt_q  <= '0;
      seq_q       <= '0;
      dim_x_q     <= '0;
      dim_y_q     <= '0;
      dim_z_q     <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      clr_pend_q  <= clr_pend_d;
      clr_cnt_q   <= clr_cnt_d;
      merge_q     <= merge_d;
      wr_cnt_q    <= wr_cnt_d;
      miss_cnt_q  <= miss_cnt_d;
      named_cnt_q <= named_cnt_d;
      idx_cnt_q   <= idx_cnt_d;
      disp_cnt_q  <= disp_cnt_d;
      seq_q       <= seq_d;
      dim_x_q     <= dim_x_d;
      dim_y_q     <= dim_y_d;
      dim_z_q     <= dim_z_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) item_q <= in_data_i;
    res_q <= res_d;
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // memory writes only come from execution or the clearing sweep
  a_we_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (state_q == bgrf_pkg::ST_EXEC || state_q == bgrf_pkg::ST_CLEAR))
    else $error("store written outside execute or clear");

  // the sweep visits consecutive entries
  a_clr_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($past(rst_ni) && state_q == bgrf_pkg::ST_CLEAR &&
     $past(state_q) == bgrf_pkg::ST_CLEAR)
    |-> clr_cnt_q == $past(clr_cnt_q) + bgrf_pkg::IDX_W'(1))
    else $error("clear sweep skipped an entry");

  // a pending result is delivered once the output register is free
  a_done_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == bgrf_pkg::ST_DONE && out_free) |=>
    (out_valid_q && state_q == bgrf_pkg::ST_IDLE))
    else $error("finished result not delivered");

  // a stalled result is not dropped
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |=> out_valid_q)
    else $error("stalled result dropped");

endmodule

### hw/rtl/bgrf_locate.sv
// ----------------------------------------------------------------------------
// bgrf_locate
// Matches a dword address against the four banks and forms the flat index.
// ----------------------------------------------------------------------------
module bgrf_locate (
  input  logic [bgrf_pkg::NUM_BANKS-1:0][31:0] bases_i,
  input  logic [31:0]                          address_i,
  output bgrf_pkg::loc_t                       loc_o
);

  logic [bgrf_pkg::NUM_BANKS-1:0]                      bank_hit;
  logic [bgrf_pkg::NUM_BANKS-1:0][bgrf_pkg::IDX_W-1:0] bank_idx;
  logic [bgrf_pkg::NUM_BANKS-1:0][31:0]                diff;

  // per bank range check, no wrap past 32 bits
  always_comb begin
    for (int b = 0; b < bgrf_pkg::NUM_BANKS; b++) begin
      diff[b]     = address_i - bases_i[b];
      bank_hit[b] = (address_i >= bases_i[b]) &&
                    (diff[b] < 32'(bgrf_pkg::BANK_WORDS[b]));
      bank_idx[b] = bgrf_pkg::IDX_W'(bgrf_pkg::BANK_OFFSET[b]) +
                    diff[b][bgrf_pkg::IDX_W-1:0];
    end
  end

  // first bank in order wins
  always_comb begin
    loc_o.hit     = 1'b0;
    loc_o.idx     = '0;
    for (int b = bgrf_pkg::NUM_BANKS - 1; b >= 0; b--) begin
      if (bank_hit[b]) begin
        loc_o.hit = 1'b1;
        loc_o.idx = bank_idx[b];
      end
    end
    loc_o.ctx_hit = bank_hit[bgrf_pkg::CTX_BANK];
    loc_o.ctx_idx = bank_idx[bgrf_pkg::CTX_BANK];
  end

endmodule

### hw/rtl/bgrf_mem.sv
// ----------------------------------------------------------------------------
// bgrf_mem
// Register word store with written flags, one write and one read port.
// ----------------------------------------------------------------------------
module bgrf_mem (
  input  logic                                clk_i,
  input  logic                                we_i,
  input  logic [bgrf_pkg::IDX_W-1:0]          waddr_i,
  input  logic [bgrf_pkg::ENTRY_W-1:0]        wdata_i,
  input  logic                                re_i,
  input  logic [bgrf_pkg::IDX_W-1:0]          raddr_i,
  output logic [bgrf_pkg::ENTRY_W-1:0]        rdata_o
);

  logic [bgrf_pkg::ENTRY_W-1:0] mem [bgrf_pkg::TOTAL_WORDS];
  logic [bgrf_pkg::ENTRY_W-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // registered read, same-cycle write to the same entry is forwarded
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      if (we_i && (waddr_i == raddr_i)) begin
        rdata_q <= wdata_i;
      end else begin
        rdata_q <= mem[raddr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule
